@@ design/aesctr_pkg.sv @@
// ----------------------------------------------------------------------------
// aesctr_pkg
// shared types, function codes and aes helper functions for the ctr engine
// ----------------------------------------------------------------------------
package aesctr_pkg;

	typedef enum logic [1:0] {
		FUNC_LOAD_KEY = 2'd0,
		FUNC_LOAD_CTR = 2'd1,
		FUNC_DATA     = 2'd2,
		FUNC_NONE     = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  key_round;
		logic [63:0] word_high;
		logic [63:0] word_low;
		logic [4:0]  byte_count;
	} in_word_t;

	typedef struct packed {
		logic [63:0] text_high;
		logic [63:0] text_low;
		logic [63:0] counter_high;
		logic [63:0] counter_low;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY2,
		ST_INIT,
		ST_ROUND,
		ST_OUT
	} state_t;

	localparam logic [3:0] MIN_ROUNDS = 4'd10;

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] p;
		x = a;
		p = 8'd0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x;
			x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	// s-box entry from the field inverse and the affine map
	function automatic logic [7:0] sbox_calc(input logic [7:0] v);
		logic [7:0] acc;
		logic [7:0] base;
		logic [7:0] e;
		acc = 8'd1;
		base = v;
		e = 8'd254;
		for (int i = 0; i < 8; i++) begin
			if (e[i]) acc = gmul(acc, base);
			base = gmul(base, base);
		end
		return acc ^ {acc[6:0], acc[7]} ^ {acc[5:0], acc[7:6]}
			^ {acc[4:0], acc[7:5]} ^ {acc[3:0], acc[7:4]} ^ 8'h63;
	endfunction

	function automatic logic [2047:0] sbox_fill();
		logic [2047:0] t;
		t = '0;
		for (int i = 0; i < 256; i++) t[8*i +: 8] = sbox_calc(8'(i));
		return t;
	endfunction

	// constant lookup table, entry v in bits 8v+7..8v
	localparam logic [2047:0] SBOX_TABLE = sbox_fill();

	function automatic logic [7:0] sbox(input logic [7:0] v);
		return SBOX_TABLE[{v, 3'b000} +: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// one round without key addition; byte 0 sits in the top bits
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, all;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) b[i] = s[127 - 8*i -: 8];
		for (int c = 0; c < 4; c++)
			for (int k = 0; k < 4; k++)
				t[k + 4*c] = sbox(b[k + 4*((c + k) % 4)]);
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				all = a0 ^ a1 ^ a2 ^ a3;
				t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
		return r;
	endfunction

endpackage

@@ design/aesctr_ram.sv @@
// ----------------------------------------------------------------------------
// aesctr_ram
// generic single-port write, single-port read ram with registered read
// ----------------------------------------------------------------------------
module aesctr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 30
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ design/aes_ctr_stream_cipher_core.sv @@
// ----------------------------------------------------------------------------
// aes_ctr_stream_cipher_core
// aes-128/192/256 counter mode engine with external key expansion
// ----------------------------------------------------------------------------
// every accepted word gives exactly one result word. a key load writes the
// high 64-bit half of one round key into the key ram at accept and the low
// half in ST_KEY2, and a counter load just sets the counter; each reports the
// counter with zero text. a data word runs the counter through num_rounds
// aes rounds (clamped to 10..MAX_ROUNDS) on one state register, with the
// round keys streamed out of a 64-bit wide key ram with registered read (two
// reads per key, so key fetch is overlapped with the round before). the two
// reads per key set the pace of the rounds. the result sits in an output
// register and the next word is taken once it has been delivered.
module aes_ctr_stream_cipher_core #(
	parameter int MAX_ROUNDS = 14
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  aesctr_pkg::in_word_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output aesctr_pkg::out_word_t  out_data,
	input  logic                   cfg_we,
	input  logic [3:0]             cfg_wdata
);
	import aesctr_pkg::*;

	localparam int KW = 2 * (MAX_ROUNDS + 1);
	localparam int AW = $clog2(KW);
	localparam logic [3:0] MAXR = 4'(MAX_ROUNDS);

	state_t state_q, state_d;
	logic [3:0]   num_rounds_q;
	logic [3:0]   nr;
	in_word_t     item_q;
	logic [127:0] ctr_q;
	logic [127:0] st_q;
	logic [63:0]  khi_q;
	logic [3:0]   rnd_q;          // key index currently being fetched
	logic         half_q;         // 0: high half read issued, 1: low half
	logic         we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0]  wdata, rdata;
	logic [127:0] rk;
	logic [127:0] ks;
	logic [4:0]   cnt;
	logic         last_step;

	// clamp the round count
	always_comb begin
		nr = num_rounds_q;
		if (nr < MIN_ROUNDS) nr = MIN_ROUNDS;
		if (nr > MAXR) nr = MAXR;
	end

	assign rk = {khi_q, rdata};

	// last key fully read, final key add happens here
	assign last_step = (state_q == ST_ROUND) && !half_q && (rnd_q == nr + 4'd1);

	aesctr_ram #(.WIDTH(64), .DEPTH(KW)) u_key_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// key writes: high half at accept, low half in ST_KEY2
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = item_q.word_low;
		if (state_q == ST_KEY2 && item_q.key_round <= MAXR) begin
			we = 1'b1;
			waddr = AW'({item_q.key_round, 1'b1});
		end else if (in_valid && in_ready && in_data.func == FUNC_LOAD_KEY
				&& in_data.key_round <= MAXR) begin
			we = 1'b1;
			waddr = AW'({in_data.key_round, 1'b0});
			wdata = in_data.word_high;
		end
	end

	assign raddr = AW'({rnd_q, half_q});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid && in_ready) begin
				if (in_data.func == FUNC_LOAD_KEY) state_d = ST_KEY2;
				else if (in_data.func == FUNC_DATA && in_data.byte_count != 5'd0)
					state_d = ST_INIT;
				else state_d = ST_OUT;
			end
			ST_KEY2:  state_d = ST_OUT;
			ST_INIT:  if (half_q) state_d = ST_ROUND;
			ST_ROUND: if (last_step) state_d = ST_OUT;
			ST_OUT:   if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			num_rounds_q <= MIN_ROUNDS;
			ctr_q <= '0;
			rnd_q <= '0;
			half_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) num_rounds_q <= cfg_wdata;
			if (state_q == ST_IDLE) begin
				rnd_q <= '0;
				half_q <= 1'b0;
				if (in_valid && in_data.func == FUNC_LOAD_CTR)
					ctr_q <= {in_data.word_high, in_data.word_low};
			end else if (state_q == ST_INIT || state_q == ST_ROUND) begin
				half_q <= ~half_q;
				if (half_q) rnd_q <= rnd_q + 4'd1;
				if (last_step)
					ctr_q <= ctr_q + 128'd1;
			end
		end
	end

	// keystream state; rdata holds the half addressed last cycle, so the
	// high half shows up while the low half read is being issued
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_q <= in_data;
		if (half_q) khi_q <= rdata;
		if (state_q == ST_INIT && half_q) st_q <= ctr_q;
		else if (state_q == ST_ROUND && !half_q && rnd_q <= nr) begin
			if (rnd_q == 4'd1) st_q <= st_q ^ rk;
			else st_q <= aes_round(st_q, 1'b0) ^ rk;
		end else if (state_q == ST_ROUND && half_q && rnd_q == nr)
			st_q <= aes_round(st_q, 1'b1);
	end

	// final key add and masking, from the finished state and last round key
	always_comb begin
		ks = st_q ^ rk;
		cnt = (item_q.byte_count > 5'd16) ? 5'd16 : item_q.byte_count;
	end

	logic [127:0] txt_q;
	logic [127:0] d128;
	logic [127:0] mask;
	always_comb begin
		d128 = {item_q.word_high, item_q.word_low};
		for (int i = 0; i < 16; i++)
			mask[127 - 8*i -: 8] = (5'(i) < cnt) ? 8'hff : 8'h00;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) txt_q <= '0;
		else if (last_step)
			txt_q <= (d128 ^ ks) & mask;
	end

	assign out_data = '{text_high: txt_q[127:64], text_low: txt_q[63:0],
		counter_high: ctr_q[127:64], counter_low: ctr_q[63:0]};

	a_one_hot_io: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready and valid together");
	a_ctr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && state_d == ST_OUT) |=> ctr_q == $past(ctr_q) + 128'd1)
		else $error("counter did not advance");
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> rnd_q <= nr + 4'd1) else $error("round overrun");
endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// aes ctr engine check: directed and random words, own aes predictor
// ----------------------------------------------------------------------------
// words are queued by the stimulus block and driven at the falling edge; the
// monitor compares each result word with the oldest predicted one. the
// predictor keeps its own round key store, counter and round count. data
// words are only sent once every round key up to the current round count
// has been written.
module tb;
	import aesctr_pkg::*;

	localparam int  KEY_SLOTS   = 15;
	localparam int  STALL_LIMIT = 20000;
	localparam int  N_RANDOM    = 1560;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_word_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_word_t   out_data;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;

	aes_ctr_stream_cipher_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [127:0] mdl_keys [KEY_SLOTS];
	logic [127:0] mdl_counter;
	logic [3:0]   mdl_rounds;
	logic [7:0]   sb [256];

	in_word_t  pending_words [$];
	out_word_t expected_words [$];
	int        mismatches;
	int        idle_cycles;
	int        send_idle_pct;
	int        recv_stall_pct;
	bit        timed_out;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
		logic [7:0] p;
		p = 0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic void build_subst();
		logic [7:0] inv;
		logic [7:0] pw;
		for (int v = 0; v < 256; v++) begin
			// inverse as v^254
			inv = 8'd1;
			pw = v[7:0];
			for (int i = 1; i < 8; i++) begin
				pw = gf_times(pw, pw);
				inv = gf_times(inv, pw);
			end
			sb[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
				^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
		end
	endfunction

	function automatic logic [7:0] dbl(logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] cipher_round(logic [127:0] s, bit last_round,
			logic [127:0] rk);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, mix;
		logic [127:0] r;
		for (int c = 0; c < 4; c++)
			for (int k = 0; k < 4; k++)
				t[k + 4*c] = sb[s[127 - 8*(k + 4*((c + k) % 4)) -: 8]];
		if (!last_round) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				mix = a0 ^ a1 ^ a2 ^ a3;
				t[4*c]   = a0 ^ mix ^ dbl(a0 ^ a1);
				t[4*c+1] = a1 ^ mix ^ dbl(a1 ^ a2);
				t[4*c+2] = a2 ^ mix ^ dbl(a2 ^ a3);
				t[4*c+3] = a3 ^ mix ^ dbl(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
		return r ^ rk;
	endfunction

	function automatic int eff_rounds();
		if (mdl_rounds < MIN_ROUNDS) return MIN_ROUNDS;
		if (mdl_rounds > 14) return 14;
		return mdl_rounds;
	endfunction

	// expected result of one word, state advanced
	function automatic out_word_t predict_ctr_word(in_word_t w);
		out_word_t  res;
		logic [127:0] ks;
		logic [127:0] txt;
		int nb;
		int nr;
		txt = 0;
		if (w.func == FUNC_LOAD_KEY) begin
			if (w.key_round < KEY_SLOTS)
				mdl_keys[w.key_round] = {w.word_high, w.word_low};
		end else if (w.func == FUNC_LOAD_CTR) begin
			mdl_counter = {w.word_high, w.word_low};
		end else if (w.func == FUNC_DATA && w.byte_count != 0) begin
			nr = eff_rounds();
			nb = (w.byte_count > 16) ? 16 : w.byte_count;
			ks = mdl_counter ^ mdl_keys[0];
			for (int r = 1; r <= nr; r++)
				ks = cipher_round(ks, r == nr, mdl_keys[r]);
			txt = {w.word_high, w.word_low} ^ ks;
			for (int i = 0; i < 16; i++)
				if (i >= nb) txt[127 - 8*i -: 8] = 8'h00;
			mdl_counter = mdl_counter + 128'd1;
		end
		res.text_high = txt[127:64];
		res.text_low = txt[63:0];
		res.counter_high = mdl_counter[127:64];
		res.counter_low = mdl_counter[63:0];
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// queue a word and its prediction together
	task automatic push_word(logic [1:0] f, logic [3:0] kr, logic [63:0] hi,
			logic [63:0] lo, logic [4:0] nb);
		in_word_t w;
		w.func = f;
		w.key_round = kr;
		w.word_high = hi;
		w.word_low = lo;
		w.byte_count = nb;
		pending_words.push_back(w);
		expected_words.push_back(predict_ctr_word(w));
	endtask

	task automatic load_all_keys();
		for (int k = 0; k < KEY_SLOTS; k++)
			push_word(FUNC_LOAD_KEY, k[3:0], rand64(), rand64(), 5'd0);
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || expected_words.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_rounds(logic [3:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		mdl_rounds = v;
	endtask

	// one random word, mostly data blocks
	task automatic push_random();
		int sel;
		logic [4:0] nb;
		sel = $urandom_range(0, 99);
		if (sel < 4)
			push_word(FUNC_LOAD_KEY, 4'($urandom_range(0, 15)), rand64(), rand64(),
				5'($urandom));
		else if (sel < 10)
			push_word(FUNC_LOAD_CTR, 4'($urandom), rand64(),
				($urandom_range(0, 3) == 0)
					? 64'hffff_ffff_ffff_fff0 | 64'($urandom_range(0, 15))
					: rand64(), 5'($urandom));
		else if (sel < 12)
			push_word(FUNC_NONE, 4'($urandom), rand64(), rand64(), 5'($urandom));
		else begin
			sel = $urandom_range(0, 9);
			nb = (sel < 6) ? 5'd16 : (sel < 9) ? 5'($urandom_range(0, 15))
				: 5'($urandom_range(17, 31));
			push_word(FUNC_DATA, 4'($urandom), rand64(), rand64(), nb);
		end
	endtask

	// accept tracking
	bit accepted_now;
	always @(posedge clk) begin
		accepted_now <= in_valid && in_ready;
	end

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			out_ready <= 1'b0;
		end else begin
			if (accepted_now && pending_words.size() != 0)
				void'(pending_words.pop_front());
			if ((!in_valid || accepted_now) && pending_words.size() != 0
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_words[0];
			end else if (!in_valid || accepted_now) begin
				in_valid <= 1'b0;
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if ((in_valid && in_ready)
					|| (out_valid && out_ready && expected_words.size() != 0))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %h", out_data);
				end else begin
					want = expected_words.pop_front();
					if (out_data.text_high !== want.text_high
							|| out_data.text_low !== want.text_low
							|| out_data.counter_high !== want.counter_high
							|| out_data.counter_low !== want.counter_low) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h %h %h %h got %h %h %h %h",
								want.text_high, want.text_low, want.counter_high,
								want.counter_low, out_data.text_high, out_data.text_low,
								out_data.counter_high, out_data.counter_low);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic [3:0] rsel [4];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 4'd0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mdl_counter = 0;
		mdl_rounds = 4'd10;
		build_subst();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: keys, counter wrap, partial, zero and oversized counts
		load_all_keys();
		push_word(FUNC_LOAD_KEY, 4'd15, '1, '1, 5'd0);
		push_word(FUNC_LOAD_CTR, 4'd0, '1, '1, 5'd0);
		push_word(FUNC_DATA, 4'd0, '1, '1, 5'd16);
		push_word(FUNC_DATA, 4'd0, '0, '0, 5'd1);
		push_word(FUNC_DATA, 4'd0, '1, '0, 5'd0);
		push_word(FUNC_DATA, 4'd0, '1, '1, 5'd31);
		push_word(FUNC_DATA, 4'd0, rand64(), rand64(), 5'd15);
		push_word(FUNC_DATA, 4'd0, rand64(), rand64(), 5'd8);
		push_word(FUNC_NONE, 4'hf, '1, '1, 5'h1f);
		push_word(FUNC_LOAD_CTR, 4'd0, 64'd0, 64'hffff_ffff_ffff_ffff, 5'd0);
		push_word(FUNC_DATA, 4'd0, '0, '0, 5'd16);
		drain();

		// phases over round counts and idling mixes
		rsel[0] = 4'd0; rsel[1] = 4'd15; rsel[2] = 4'd12; rsel[3] = 4'd11;
		for (int ph = 0; ph < 8; ph++) begin
			write_rounds((ph < 4) ? rsel[ph] : 4'($urandom_range(9, 14)));
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 72; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 72; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			load_all_keys();
			for (int i = 0; i < N_RANDOM / 8; i++) push_random();
			drain();
		end
		write_rounds(4'd10);

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

@@ filelist.f @@
design/aesctr_pkg.sv
design/aesctr_ram.sv
design/aes_ctr_stream_cipher_core.sv
tb/sv/tb.sv
